// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the kernel generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define GKG_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle of its antecedent.
`define GKG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gkg_pkg.sv -----
// Types and constants of the Gaussian kernel generator.
`timescale 1ns / 1ps
package gkg_pkg;

  localparam int unsigned RawW = 24;
  localparam int unsigned SumW = 32;
  localparam int unsigned DivNumW = 52;
  localparam int unsigned DivDenW = 32;
  localparam int unsigned DivCntW = 6;
  localparam int unsigned TaylorTerms = 12;
  localparam int unsigned Squarings = 6;

  typedef struct packed {
    logic [1:0]  radius;
    logic [11:0] sigma_q48;
  } gkg_req_t;

  typedef struct packed {
    logic [15:0] weight_q16;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic        last;
  } gkg_rsp_t;

  typedef struct packed {
    logic                start;
    logic [DivNumW-1:0]  num;
    logic [DivDenW-1:0]  den;
    logic [DivCntW-1:0]  count;
  } gkg_div_cmd_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quo;
  } gkg_div_sts_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ADIV,
    BK_AWAIT,
    BK_TMUL,
    BK_TDIV,
    BK_TWAIT,
    BK_SQMUL,
    BK_SQTAKE,
    BK_STORE,
    BK_NREAD,
    BK_NRAM,
    BK_NWAIT,
    BK_NOUT
  } back_state_e;

endpackage

// ----- rtl/gkg_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module gkg_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 49
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/gkg_front.sv -----
// Request intake: radius and sigma clean-up and a two-entry request queue.
`timescale 1ns / 1ps
module gkg_front import gkg_pkg::*; #(
  parameter int unsigned MAX_RADIUS = 3
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  gkg_req_t req_i,
  output logic     req_valid_o,
  output gkg_req_t req_o,
  input  logic     req_pop_i
);

`include "assert_macros.svh"

  gkg_req_t   slot_q [2];
  gkg_req_t   clean;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  always_comb begin
    clean = req_i;
    if (req_i.radius > 2'(MAX_RADIUS)) begin
      clean.radius = 2'(MAX_RADIUS);
    end
    if (req_i.sigma_q48 == '0) begin
      clean.sigma_q48 = 12'd1;
    end
  end

  assign full        = (cnt_q == 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = slot_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = req_pop_i && req_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= clean;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  `GKG_ASSERT(a_front_cnt, cnt_q <= 2'd2, "request queue count out of range")

endmodule

// ----- rtl/gkg_div.sv -----
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
module gkg_div import gkg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gkg_div_cmd_t cmd_i,
  output gkg_div_sts_t sts_o
);

`include "assert_macros.svh"

  logic [DivNumW-1:0] num_q, quo_q;
  logic [DivDenW-1:0] den_q, rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivDenW:0]   trial;
  logic               fits;

  // The numerator arrives left aligned; only its top count bits are consumed.
  assign trial = {rem_q, num_q[DivNumW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      num_q <= cmd_i.num;
      den_q <= cmd_i.den;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DivNumW-2:0], 1'b0};
      rem_q <= fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      quo_q <= {quo_q[DivNumW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.count;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sts_o.quo  = quo_q;

  `GKG_ASSERT_IMP(a_div_no_restart, busy_q, !cmd_i.start, "divider started while busy")
  `GKG_ASSERT_IMP(a_div_done_idle, done_q, !busy_q, "divider done while still busy")

endmodule

// ----- rtl/gkg_back.sv -----
// Kernel sequencer: raw weights, their sum and the normalized coefficients.
`timescale 1ns / 1ps
module gkg_back import gkg_pkg::*; #(
  parameter int unsigned MAX_RADIUS  = 3,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  gkg_req_t req_i,
  output logic     req_pop_o,
  output logic     empty,
  input  logic     pop,
  output gkg_rsp_t rsp_o
);

`include "assert_macros.svh"

  localparam int unsigned SideMax = 2 * MAX_RADIUS + 1;
  localparam int unsigned Depth   = SideMax * SideMax;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam logic [DivNumW-1:0] Top = (DivNumW'(1) << WEIGHT_BITS) - 1'b1;

  back_state_e state_q, state_d;

  logic [1:0]        r_q;
  logic [23:0]       s2_q;
  logic [2:0]        row_q, col_q;
  logic [AddrW-1:0]  idx_q;
  logic [SumW-1:0]   sum_q;
  logic [31:0]       term_q, acc_q;
  logic [29:0]       y_q;
  logic [3:0]        k_q;
  logic [2:0]        sq_q;
  logic [63:0]       prod_q;
  logic [31:0]       mul_a, mul_b;
  logic              out_valid_q;
  gkg_rsp_t          out_q;
  logic [15:0]       q_hold_q;
  logic [RawW-1:0]   raw;
  logic [RawW-1:0]   ram_rdata;
  logic              ram_we;
  logic [2:0]        side_end;
  logic [2:0]        dx, dy;
  logic [4:0]        d2;
  logic              at_row_end, at_last;
  logic              slot_free;
  logic [DivNumW-1:0] q_sat;
  gkg_div_cmd_t      div_cmd;
  gkg_div_sts_t      div_sts;

  assign side_end   = {r_q, 1'b0};
  assign at_row_end = (col_q == side_end);
  assign at_last    = at_row_end && (row_q == side_end);
  assign dx = (col_q > {1'b0, r_q}) ? col_q - {1'b0, r_q} : {1'b0, r_q} - col_q;
  assign dy = (row_q > {1'b0, r_q}) ? row_q - {1'b0, r_q} : {1'b0, r_q} - row_q;
  assign d2 = 5'(dx[1:0] * dx[1:0]) + 5'(dy[1:0] * dy[1:0]);
  assign raw = (acc_q[31:7] > 25'(2 ** RawW - 1)) ? {RawW{1'b1}} : acc_q[30:7];
  assign slot_free = !out_valid_q || pop;
  assign q_sat = (sum_q == '0) ? '0 : ((div_sts.quo > Top) ? Top : div_sts.quo);

  // One shared multiplier: Taylor terms or squaring of the accumulator.
  assign mul_a = (state_q == BK_TMUL) ? term_q : acc_q;
  assign mul_b = (state_q == BK_TMUL) ? {2'b00, y_q} : acc_q;

  always_comb begin
    state_d       = state_q;
    req_pop_o     = 1'b0;
    ram_we        = 1'b0;
    div_cmd.start = 1'b0;
    div_cmd.num   = {d2, 47'b0};
    div_cmd.den   = {8'b0, s2_q};
    div_cmd.count = DivCntW'(51);
    case (state_q)
      BK_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          state_d   = BK_ADIV;
        end
      end
      BK_ADIV: begin
        div_cmd.start = 1'b1;
        state_d       = BK_AWAIT;
      end
      BK_AWAIT: begin
        if (div_sts.done) begin
          state_d = (|div_sts.quo[DivNumW-1:36]) ? BK_STORE : BK_TMUL;
        end
      end
      BK_TMUL: begin
        state_d = BK_TDIV;
      end
      BK_TDIV: begin
        div_cmd.start = 1'b1;
        div_cmd.num   = {prod_q[61:31], 21'b0};
        div_cmd.den   = {28'b0, k_q};
        div_cmd.count = DivCntW'(31);
        state_d       = BK_TWAIT;
      end
      BK_TWAIT: begin
        if (div_sts.done) begin
          state_d = (k_q == 4'(TaylorTerms)) ? BK_SQMUL : BK_TMUL;
        end
      end
      BK_SQMUL: begin
        state_d = BK_SQTAKE;
      end
      BK_SQTAKE: begin
        state_d = (sq_q == 3'(Squarings - 1)) ? BK_STORE : BK_SQMUL;
      end
      BK_STORE: begin
        ram_we  = 1'b1;
        state_d = at_last ? BK_NREAD : BK_ADIV;
      end
      BK_NREAD: begin
        if (slot_free) begin
          state_d = BK_NRAM;
        end
      end
      BK_NRAM: begin
        div_cmd.start = 1'b1;
        div_cmd.num   = DivNumW'({ram_rdata, {(DivNumW - RawW){1'b0}}});
        div_cmd.den   = sum_q;
        div_cmd.count = DivCntW'(RawW + WEIGHT_BITS);
        state_d       = BK_NWAIT;
      end
      BK_NWAIT: begin
        if (div_sts.done) begin
          state_d = BK_NOUT;
        end
      end
      BK_NOUT: begin
        if (slot_free) begin
          state_d = at_last ? BK_IDLE : BK_NREAD;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_NOUT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == BK_IDLE) begin
        sum_q <= '0;
      end else if (state_q == BK_STORE) begin
        sum_q <= sum_q + SumW'(raw);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      BK_IDLE: begin
        r_q   <= req_i.radius;
        s2_q  <= req_i.sigma_q48 * req_i.sigma_q48;
        row_q <= '0;
        col_q <= '0;
        idx_q <= '0;
      end
      BK_AWAIT: begin
        if (div_sts.done) begin
          y_q    <= div_sts.quo[35:6];
          term_q <= 32'h8000_0000;
          k_q    <= 4'd1;
          sq_q   <= '0;
          acc_q  <= (|div_sts.quo[DivNumW-1:36]) ? 32'd0 : 32'h8000_0000;
        end
      end
      BK_TWAIT: begin
        if (div_sts.done) begin
          term_q <= div_sts.quo[31:0];
          acc_q  <= k_q[0] ? acc_q - div_sts.quo[31:0] : acc_q + div_sts.quo[31:0];
          k_q    <= k_q + 1'b1;
        end
      end
      BK_SQTAKE: begin
        acc_q <= prod_q[62:31];
        sq_q  <= sq_q + 1'b1;
      end
      BK_STORE, BK_NOUT: begin
        if (state_q == BK_STORE || slot_free) begin
          if (at_last) begin
            row_q <= '0;
            col_q <= '0;
            idx_q <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
            if (at_row_end) begin
              col_q <= '0;
              row_q <= row_q + 1'b1;
            end else begin
              col_q <= col_q + 1'b1;
            end
          end
        end
        if (state_q == BK_NOUT && slot_free) begin
          out_q.weight_q16 <= q_hold_q;
          out_q.row_index  <= row_q;
          out_q.col_index  <= col_q;
          out_q.last       <= at_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_NWAIT && div_sts.done) begin
      q_hold_q <= q_sat[15:0];
    end
  end

  gkg_ram #(
    .WIDTH(RawW),
    .DEPTH(Depth)
  ) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (raw),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  gkg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .sts_o  (div_sts)
  );

  assign empty = !out_valid_q;
  assign rsp_o = out_q;

  `GKG_ASSERT_IMP(a_back_sum_nz, state_q == BK_NWAIT, sum_q != '0,
    "normalizing against a zero weight sum")

endmodule

// ----- rtl/gaussian_kernel_generator.sv -----
// Top level of the normalized 2-D Gaussian kernel generator.
//
//  channel   direction  handshake            payload
//  request   in         push / full         req_i  (radius, sigma_q48)
//  result    out        empty / pop         rsp_o  (weight_q16, row_index, col_index, last)
//
// A request of radius r yields N = (2r+1)^2 coefficient transfers in row-major order.
// Each raw weight takes one 51-step exponent division in the shared bit-serial
// divider and twelve 31-step Taylor term divisions, plus six squarings. Each
// coefficient then takes its own normalizing division in the same divider.
// Reset clears the request queue, the sequencer and the result valid flag.
// A result that is not popped holds the sequencer; two further requests queue meanwhile.
`timescale 1ns / 1ps
module gaussian_kernel_generator import gkg_pkg::*; #(
  parameter int unsigned MAX_RADIUS  = 3,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  gkg_req_t req_i,
  output logic     empty,
  input  logic     pop,
  output gkg_rsp_t rsp_o
);

  // Cleaned requests wait in the front queue until the sequencer is free.
  logic     req_valid;
  logic     req_pop;
  gkg_req_t req;

  gkg_front #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  // The back end builds the raw weights, sums them and emits normalized values.
  gkg_back #(
    .MAX_RADIUS  (MAX_RADIUS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- tb/gkg_checker.sv -----
// Result checker for the Gaussian kernel generator: predicts coefficients and compares them.
`timescale 1ns / 1ps
module gkg_checker import gkg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  logic     full_i,
  input  gkg_req_t req_i,
  input  logic     empty_i,
  input  logic     pop_i,
  input  gkg_rsp_t rsp_i,
  output int       errors_o,
  output int       pending_o,
  output int       coefs_o
);

  localparam int unsigned SideMax = 7;
  localparam logic [63:0] QOne = 64'd1 << 31;
  localparam logic [63:0] ExpLimit = 64'd1 << 36;

  gkg_rsp_t coef_q[$];

  // Raw weight exp(-d2 / (2 sigma^2)) in Q24, computed the way the hardware does.
  function automatic logic [23:0] raw_weight(logic [63:0] d2, logic [63:0] s);
    logic [63:0] a, y, term, acc, r;
    a = (d2 << 46) / (s * s);
    if (a >= ExpLimit) return 24'd0;
    y = a >> 6;
    term = QOne;
    acc = QOne;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 31) / 64'(k);
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    r = acc;
    for (int k = 0; k < 6; k++) r = (r * r) >> 31;
    r = r >> 7;
    if (r > 64'hFFFFFF) r = 64'hFFFFFF;
    return r[23:0];
  endfunction

  task automatic predict_kernel(gkg_req_t req);
    logic [23:0] raw [SideMax*SideMax];
    logic [31:0] total;
    logic [63:0] s, q, dx, dy;
    int radius, side;
    gkg_rsp_t c;
    radius = int'(req.radius);
    if (radius > 3) radius = 3;
    s = 64'(req.sigma_q48);
    if (s == 0) s = 1;
    side = 2 * radius + 1;
    total = '0;
    for (int row = 0; row < side; row++) begin
      for (int col = 0; col < side; col++) begin
        dx = 64'((col > radius) ? col - radius : radius - col);
        dy = 64'((row > radius) ? row - radius : radius - row);
        raw[row*side+col] = raw_weight(dx * dx + dy * dy, s);
        total = total + 32'(raw[row*side+col]);
      end
    end
    for (int row = 0; row < side; row++) begin
      for (int col = 0; col < side; col++) begin
        if (total == 0) q = 0;
        else q = (64'(raw[row*side+col]) << 16) / 64'(total);
        if (q > 64'hFFFF) q = 64'hFFFF;
        c.weight_q16 = q[15:0];
        c.row_index  = 3'(row);
        c.col_index  = 3'(col);
        c.last       = (row == side - 1) && (col == side - 1);
        coef_q.push_back(c);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gkg_rsp_t exp_c;
    if (!rst_ni) begin
      coef_q.delete();
      errors_o <= 0;
      coefs_o <= 0;
    end else begin
      if (push_i && !full_i) predict_kernel(req_i);
      if (pop_i && !empty_i) begin
        coefs_o <= coefs_o + 1;
        if (coef_q.size() == 0) begin
          $display("%0t: coefficient transfer with none expected: %p", $time, rsp_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_c = coef_q.pop_front();
          if (rsp_i !== exp_c) begin
            $display("%0t: coefficient mismatch: expected %p, actual %p", $time, exp_c, rsp_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
    pending_o <= coef_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the Gaussian kernel generator testbench: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_top;
  import gkg_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     full;
  gkg_req_t req = '0;
  logic     empty;
  logic     pop = 1'b0;
  gkg_rsp_t rsp;

  int errors, pending, coefs;
  int send_idle_pct = 0;   // Chance per cycle that the sender pauses.
  int recv_stall_pct = 0;  // Chance per cycle that the receiver stalls.
  bit hold_req = 1'b0;     // Asks the receiver for one long hold-off.
  int requests = 0;
  int big_kernels = 0;
  int quiet_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  gaussian_kernel_generator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req),
    .empty (empty),
    .pop   (pop),
    .rsp_o (rsp)
  );

  gkg_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_i   (full),
    .req_i    (req),
    .empty_i  (empty),
    .pop_i    (pop),
    .rsp_i    (rsp),
    .errors_o (errors),
    .pending_o(pending),
    .coefs_o  (coefs)
  );

  // The watchdog counts cycles in which neither side completes a transfer. Its
  // limit leaves a wide margin for the slowest kernel on top of receiver stalls.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 300000) begin
      $display("gaussian_kernel_generator regression: fail");
      $finish;
    end
  end

  // Receiver: decides at every falling edge whether to take the waiting result.
  // A long hold-off, when asked for, is counted here so that the input queue
  // fills up behind a held result and the block has to raise full.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop = 1'b0;
        repeat (3000) @(negedge clk_i);
        hold_req = 1'b0;
      end
      pop = rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Radius is kept mostly small: a radius-3 kernel is the most costly.
  function automatic logic [1:0] pick_radius();
    int p;
    p = $urandom_range(99);
    if (p < 48) return 2'd0;
    if (p < 89) return 2'd1;
    if (p < 97) return 2'd2;
    return 2'd3;
  endfunction

  // Sigma covers the whole field: the normal range, narrow kernels where the
  // outer weights vanish, and the small values below the stated range.
  function automatic logic [11:0] pick_sigma();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 12'($urandom_range(4095, 16));
    if (p < 90) return 12'($urandom_range(400, 16));
    return 12'($urandom_range(15, 0));
  endfunction

  // Offers one request from a falling edge and holds it until the transfer.
  task automatic send_request(logic [1:0] radius, logic [11:0] sigma);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    req.radius = radius;
    req.sigma_q48 = sigma;
    push = 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    requests++;
    if (radius == 2'd3) big_kernels++;
    @(negedge clk_i);
    push = 1'b0;
    req = gkg_req_t'($urandom());
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: every radius, sigma at zero, one, just below and at the
    // bottom of its range, and at the top of the field.
    send_request(2'd0, 12'd16);
    send_request(2'd0, 12'd0);
    send_request(2'd1, 12'd0);
    send_request(2'd1, 12'd1);
    send_request(2'd1, 12'd15);
    send_request(2'd1, 12'd16);
    send_request(2'd1, 12'd4095);
    send_request(2'd1, 12'd256);
    send_request(2'd2, 12'd16);
    send_request(2'd2, 12'd4095);
    send_request(2'd2, 12'd384);
    send_request(2'd3, 12'd4095);
    send_request(2'd3, 12'd300);
    send_request(2'd0, 12'd2730);
    send_request(2'd1, 12'd1365);

    // Random phases with different amounts of idling on each side.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int n = 0; n < 66; n++) begin
        if (phase == 2 && n == 10) hold_req = 1'b1;
        send_request(pick_radius(), pick_sigma());
      end
    end

    // Drain everything, then watch a while longer for stray results.
    while (pending != 0 || hold_req) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);

    $display("Covered %0d kernel requests (%0d of radius three) and %0d coefficients,",
             requests, big_kernels, coefs);
    $display("under four idling mixes plus one long result hold-off.");
    if (errors == 0) begin
      $display("gaussian_kernel_generator regression: pass");
    end else begin
      $display("gaussian_kernel_generator regression: fail");
    end
    $finish;
  end

endmodule
